@@ rtl/wfdr_pkg.sv @@
// Shared constants, types and codes for the weighted FDR adjustment block.
`default_nettype none
package wfdr_pkg;

  localparam int MAX_SPOTS = 64;
  localparam int ADDR_W    = $clog2(MAX_SPOTS);
  localparam int CNT_W     = ADDR_W + 1;

  localparam int P_W   = 17;
  localparam int M_W   = 16;
  localparam int W_W   = 24;
  localparam int TOT_W = 32;
  localparam int KEY_W = P_W + 1;

  localparam int DVD_W = 48;
  localparam int DVS_W = 32;
  localparam int BIT_W = $clog2(DVD_W);

  localparam logic [P_W-1:0]   ONE_Q16    = P_W'(65536);
  localparam logic [W_W-1:0]   ONE_W      = W_W'(65536);
  localparam logic [W_W-1:0]   WEIGHT_MAX = {W_W{1'b1}};
  localparam logic [DVD_W-1:0] WEIGHT_NUM = DVD_W'(64'd1 << 28);
  localparam logic [BIT_W-1:0] WEIGHT_BITS = BIT_W'(29);
  localparam logic [BIT_W-1:0] ADJ_BITS    = BIT_W'(DVD_W);
  localparam logic [KEY_W-1:0] KEY_MISSING = KEY_W'(1) << P_W;
  localparam logic [CNT_W-1:0] CAPACITY    = CNT_W'(MAX_SPOTS);

  typedef struct packed {
    logic [P_W-1:0] p_value;
    logic           p_missing;
    logic [W_W-1:0] weight;
    logic           last_spot;
  } spot_t;

  typedef struct packed {
    logic [P_W-1:0] p_value;
    logic           p_missing;
    logic [W_W-1:0] weight;
  } spot_word_t;

  localparam int SPOT_WORD_W = $bits(spot_word_t);

endpackage
`default_nettype wire

@@ rtl/wfdr_if.sv @@
// Valid/ready channel interfaces for spot items and adjusted results.
`default_nettype none
interface wfdr_in_if;
  import wfdr_pkg::*;
  logic           valid;
  logic           ready;
  logic [P_W-1:0] p_value;
  logic           p_missing;
  logic [M_W-1:0] neighbor_max_weight;
  logic           last_spot;
  modport source (output valid, p_value, p_missing, neighbor_max_weight, last_spot,
                  input ready);
  modport sink   (input valid, p_value, p_missing, neighbor_max_weight, last_spot,
                  output ready);
endinterface

interface wfdr_out_if;
  import wfdr_pkg::*;
  logic           valid;
  logic           ready;
  logic [P_W-1:0] adjusted_p;
  logic           adj_missing;
  logic           last_result;
  modport source (output valid, adjusted_p, adj_missing, last_result, input ready);
  modport sink   (input valid, adjusted_p, adj_missing, last_result, output ready);
endinterface
`default_nettype wire

@@ rtl/wfdr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module wfdr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ rtl/wfdr_div.sv @@
// Restoring divider, one quotient bit per cycle over the low nbits of the dividend.
`default_nettype none
module wfdr_div import wfdr_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  input  wire logic [BIT_W-1:0] nbits,
  output      logic             done,
  output      logic [DVD_W-1:0] quotient
);
  logic             run;
  logic [DVD_W-1:0] dvd;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W-1:0] rem;
  logic [BIT_W-1:0] idx;
  logic [DVS_W:0]   trial;
  logic             take;

  assign trial = {rem, dvd[idx]};
  assign take  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
      end else if (run && idx == '0) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd      <= dividend;
      dvs      <= divisor;
      rem      <= '0;
      quotient <= '0;
      idx      <= nbits - BIT_W'(1);
    end else if (run) begin
      rem      <= take ? DVS_W'(trial - {1'b0, dvs}) : trial[DVS_W-1:0];
      quotient <= {quotient[DVD_W-2:0], take};
      idx      <= idx - BIT_W'(1);
    end
  end
endmodule
`default_nettype wire

@@ rtl/wfdr_front.sv @@
// Front end: takes spot items and turns the neighbor weight into a spot weight.
`default_nettype none
module wfdr_front import wfdr_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  wfdr_in_if.sink     in_ch,
  output      logic   push_valid,
  output      spot_t  push_data,
  input  wire logic   push_ready
);
  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_DIV  = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  logic [1:0]       state;
  logic [P_W-1:0]   p;
  logic             miss;
  logic             last;
  logic [M_W-1:0]   m;
  logic [W_W-1:0]   weight;
  logic             accept;
  logic             div_done;
  logic [DVD_W-1:0] quo;

  assign in_ch.ready = (state == F_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign push_valid  = (state == F_PUSH);
  assign push_data   = '{p_value: p, p_missing: miss, weight: weight, last_spot: last};

  // round(2^28 / m) via (2^28 + m/2) / m
  wfdr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .dividend (WEIGHT_NUM + DVD_W'(in_ch.neighbor_max_weight >> 1)),
    .divisor  (DVS_W'(in_ch.neighbor_max_weight)),
    .nbits    (WEIGHT_BITS),
    .done     (div_done),
    .quotient (quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: if (accept) state <= F_DIV;
        F_DIV:  if (div_done) state <= F_PUSH;
        F_PUSH: if (push_ready) state <= F_IDLE;
        default: state <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p    <= in_ch.p_value;
      miss <= in_ch.p_missing;
      last <= in_ch.last_spot;
      m    <= in_ch.neighbor_max_weight;
    end
    if (div_done) begin
      if (m == '0) begin
        weight <= ONE_W;
      end else if (quo > DVD_W'(WEIGHT_MAX)) begin
        weight <= WEIGHT_MAX;
      end else begin
        weight <= quo[W_W-1:0];
      end
    end
  end
endmodule
`default_nettype wire

@@ rtl/wfdr_back.sv @@
// Back end: stores spots, ranks them, runs the cumulative and minimum passes, emits.
`default_nettype none
module wfdr_back import wfdr_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  pop_valid,
  input  wire spot_t pop_data,
  output      logic  pop,
  wfdr_out_if.source out_ch
);
  localparam logic [3:0] ST_LOAD   = 4'd0;
  localparam logic [3:0] ST_SRDI   = 4'd1;
  localparam logic [3:0] ST_SGETI  = 4'd2;
  localparam logic [3:0] ST_SCMP   = 4'd3;
  localparam logic [3:0] ST_SWR    = 4'd4;
  localparam logic [3:0] ST_CRDO   = 4'd5;
  localparam logic [3:0] ST_CRDS   = 4'd6;
  localparam logic [3:0] ST_CMUL   = 4'd7;
  localparam logic [3:0] ST_CSTART = 4'd8;
  localparam logic [3:0] ST_CWAIT  = 4'd9;
  localparam logic [3:0] ST_RRDO   = 4'd10;
  localparam logic [3:0] ST_RRDS   = 4'd11;
  localparam logic [3:0] ST_RUPD   = 4'd12;
  localparam logic [3:0] ST_ORD    = 4'd13;
  localparam logic [3:0] ST_OLD    = 4'd14;
  localparam logic [3:0] ST_OWAIT  = 4'd15;

  logic [3:0]       state;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] last_idx;
  logic [TOT_W-1:0] total;
  logic [CNT_W-1:0] i;
  logic [CNT_W-1:0] j;
  logic [CNT_W-1:0] k;
  logic [CNT_W-1:0] rank;
  logic [KEY_W-1:0] key_i;
  logic [KEY_W-1:0] key_j;
  logic             less;
  logic [TOT_W-1:0] cum;
  logic [DVD_W-1:0] prod;
  logic [TOT_W+P_W-1:0] prod_full;
  logic [ADDR_W-1:0] idx;
  logic [P_W-1:0]   val;
  logic [P_W-1:0]   running;
  logic [P_W-1:0]   new_min;
  logic [P_W-1:0]   clamped;

  logic             div_start;
  logic             div_done;
  logic [DVD_W-1:0] quo;

  logic              spot_we;
  spot_word_t        spot_wdata;
  logic [ADDR_W-1:0] spot_raddr;
  spot_word_t        spot_q;
  logic              sort_we;
  logic [ADDR_W-1:0] sort_q;
  logic              vals_we;
  logic [P_W-1:0]    vals_q;
  logic              adj_we;
  logic [P_W-1:0]    adj_wdata;
  logic [P_W-1:0]    adj_q;

  logic             out_valid;
  logic [P_W-1:0]   out_p;
  logic             out_miss;
  logic             out_last;

  assign last_idx   = count - CNT_W'(1);
  assign pop        = (state == ST_LOAD) && pop_valid;
  assign spot_we    = pop && (count < CAPACITY);
  assign spot_wdata = '{p_value: pop_data.p_value, p_missing: pop_data.p_missing,
                        weight: pop_data.weight};

  assign key_j = spot_q.p_missing ? KEY_MISSING : {1'b0, spot_q.p_value};
  assign less  = (key_j < key_i) || ((key_j == key_i) && (j < i));

  assign prod_full = (TOT_W+P_W)'(total) * (TOT_W+P_W)'(spot_q.p_value);
  assign div_start = (state == ST_CSTART);
  assign clamped   = (quo > DVD_W'(ONE_Q16)) ? ONE_Q16 : quo[P_W-1:0];
  assign new_min   = (val < running) ? val : running;

  assign sort_we   = (state == ST_SWR);
  assign vals_we   = (state == ST_CWAIT) && div_done;
  assign adj_we    = (state == ST_RUPD);
  assign adj_wdata = spot_q.p_missing ? '0 : new_min;

  always_comb begin
    unique case (state)
      ST_SGETI:          spot_raddr = '0;
      ST_SCMP:           spot_raddr = j[ADDR_W-1:0] + ADDR_W'(1);
      ST_CRDS, ST_RRDS:  spot_raddr = sort_q;
      default:           spot_raddr = i[ADDR_W-1:0];
    endcase
  end

  wfdr_ram #(.WIDTH(SPOT_WORD_W), .DEPTH(MAX_SPOTS)) u_spot_ram (
    .clk(clk), .we(spot_we), .waddr(count[ADDR_W-1:0]), .wdata(spot_wdata),
    .raddr(spot_raddr), .rdata(spot_q)
  );

  wfdr_ram #(.WIDTH(ADDR_W), .DEPTH(MAX_SPOTS)) u_sort_ram (
    .clk(clk), .we(sort_we), .waddr(rank[ADDR_W-1:0]), .wdata(i[ADDR_W-1:0]),
    .raddr(k[ADDR_W-1:0]), .rdata(sort_q)
  );

  wfdr_ram #(.WIDTH(P_W), .DEPTH(MAX_SPOTS)) u_vals_ram (
    .clk(clk), .we(vals_we), .waddr(k[ADDR_W-1:0]), .wdata(clamped),
    .raddr(k[ADDR_W-1:0]), .rdata(vals_q)
  );

  wfdr_ram #(.WIDTH(P_W), .DEPTH(MAX_SPOTS)) u_adj_ram (
    .clk(clk), .we(adj_we), .waddr(idx), .wdata(adj_wdata),
    .raddr(i[ADDR_W-1:0]), .rdata(adj_q)
  );

  // total * p + cum/2, divided by cum
  wfdr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod + DVD_W'(cum >> 1)),
    .divisor  (cum),
    .nbits    (ADJ_BITS),
    .done     (div_done),
    .quotient (quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      count     <= '0;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (pop) begin
            if (spot_we) begin
              count <= count + CNT_W'(1);
              total <= total + TOT_W'(pop_data.weight);
            end
            if (pop_data.last_spot) state <= ST_SRDI;
          end
        end
        ST_SRDI:   state <= ST_SGETI;
        ST_SGETI:  state <= ST_SCMP;
        ST_SCMP:   if (j == last_idx) state <= ST_SWR;
        ST_SWR:    state <= (i == last_idx) ? ST_CRDO : ST_SRDI;
        ST_CRDO:   state <= ST_CRDS;
        ST_CRDS:   state <= ST_CMUL;
        ST_CMUL:   state <= ST_CSTART;
        ST_CSTART: state <= ST_CWAIT;
        ST_CWAIT:  if (div_done) state <= (k == last_idx) ? ST_RRDO : ST_CRDO;
        ST_RRDO:   state <= ST_RRDS;
        ST_RRDS:   state <= ST_RUPD;
        ST_RUPD:   state <= (k == '0) ? ST_ORD : ST_RRDO;
        ST_ORD:    state <= ST_OLD;
        ST_OLD: begin
          out_valid <= 1'b1;
          state     <= ST_OWAIT;
        end
        ST_OWAIT: begin
          if (out_ch.ready) begin
            out_valid <= 1'b0;
            if (out_last) begin
              count <= '0;
              total <= '0;
              state <= ST_LOAD;
            end else begin
              state <= ST_ORD;
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_LOAD:  if (pop && pop_data.last_spot) i <= '0;
      ST_SGETI: begin
        key_i <= spot_q.p_missing ? KEY_MISSING : {1'b0, spot_q.p_value};
        rank  <= '0;
        j     <= '0;
      end
      ST_SCMP: begin
        rank <= rank + CNT_W'(less);
        j    <= j + CNT_W'(1);
      end
      ST_SWR: begin
        i   <= i + CNT_W'(1);
        k   <= '0;
        cum <= '0;
      end
      ST_CMUL: begin
        cum  <= cum + TOT_W'(spot_q.weight);
        prod <= prod_full[DVD_W-1:0];
      end
      ST_CWAIT: begin
        if (div_done) begin
          if (k == last_idx) begin
            running <= ONE_Q16;
          end else begin
            k <= k + CNT_W'(1);
          end
        end
      end
      ST_RRDS: begin
        idx <= sort_q;
        val <= vals_q;
      end
      ST_RUPD: begin
        if (!spot_q.p_missing) running <= new_min;
        if (k == '0) begin
          i <= '0;
        end else begin
          k <= k - CNT_W'(1);
        end
      end
      ST_OLD: begin
        out_p    <= adj_q;
        out_miss <= spot_q.p_missing;
        out_last <= (i == last_idx);
      end
      ST_OWAIT: if (out_ch.ready && !out_last) i <= i + CNT_W'(1);
      default: ;
    endcase
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.adjusted_p  = out_p;
  assign out_ch.adj_missing = out_miss;
  assign out_ch.last_result = out_last;
endmodule
`default_nettype wire

@@ rtl/weighted_fdr_adjust_top.sv @@
// Top level of the weighted Benjamini-Hochberg FDR adjustment block.
//
//   channel  dir  payload                                            transfer when
//   in_ch    in   p_value, p_missing, neighbor_max_weight, last_spot  valid && ready
//   out_ch   out  adjusted_p, adj_missing, last_result                valid && ready
//
// The front takes a new spot only after pushing the last one; the spot-weight divider
//   resolves one quotient bit per cycle over 29 bits.
// After last_spot the back ranks N spots (one compare per cycle through the spot
//   RAM read port), then runs the cumulative pass (48-bit divider) and the minimum
//   pass, one spot at a time.
// Results leave one at a time; the next is loaded only after the last is taken.
// Reset is synchronous; spot RAM contents are left as they are.
// A two-entry queue between front and back lets the front hand off up to two spots
//   while the back is busy with a set or stalled on the output.
`default_nettype none
module weighted_fdr_adjust_top import wfdr_pkg::*; (
  input wire logic   clk,
  input wire logic   rst,
  wfdr_in_if.sink    in_ch,
  wfdr_out_if.source out_ch
);
  logic  push_valid;
  logic  push_ready;
  spot_t push_data;
  logic  pop;
  logic  pop_valid;
  spot_t pop_data;

  // two-entry spot queue
  spot_t      q_mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] q_cnt;
  logic       push;

  assign push       = push_valid && push_ready;
  assign push_ready = (q_cnt != 2'd2);
  assign pop_valid  = (q_cnt != 2'd0);
  assign pop_data   = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      q_cnt  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      q_cnt <= q_cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_mem[wr_ptr] <= push_data;
  end

  wfdr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  wfdr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_data  (pop_data),
    .pop       (pop),
    .out_ch    (out_ch)
  );
endmodule
`default_nettype wire

@@ rtl/wfdr_checker.sv @@
// Port-level checks on the result channel, bound to the top level.
`default_nettype none
module wfdr_checker import wfdr_pkg::*; (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           out_valid,
  input wire logic           out_ready,
  input wire logic [P_W-1:0] adjusted_p,
  input wire logic           adj_missing,
  input wire logic           last_result
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(adjusted_p) && $stable(adj_missing)
                                && $stable(last_result))
    else $error("result changed while stalled");

  a_clamp: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> adjusted_p <= ONE_Q16)
    else $error("adjusted value above one");

  a_missing: assert property (@(posedge clk) disable iff (rst)
    out_valid && adj_missing |-> adjusted_p == '0)
    else $error("missing spot with nonzero value");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");
endmodule

bind weighted_fdr_adjust_top wfdr_checker u_wfdr_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .adjusted_p  (out_ch.adjusted_p),
  .adj_missing (out_ch.adj_missing),
  .last_result (out_ch.last_result)
);
`default_nettype wire
